// File: hdl/gate_motor_command_controller_defines.svh
// ----------------------------------------------------------------------------
// Gate motor command controller assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off while in reset.
// ----------------------------------------------------------------------------
`ifndef GATE_MOTOR_COMMAND_CONTROLLER_DEFINES_SVH
`define GATE_MOTOR_COMMAND_CONTROLLER_DEFINES_SVH

// full property, checked outside reset
`define GMCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication
`define GMCC_ASSERT_IMP(lbl, ante, cons, msg) \
  `GMCC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: hdl/gmcc_pkg.sv
// ----------------------------------------------------------------------------
// Gate motor command controller package
// Item types, state encodings, command codes and arithmetic constants.
// ----------------------------------------------------------------------------
package gmcc_pkg;

  localparam int PERIOD_W = 16;
  localparam int PCT_W    = 7;
  localparam int SENSE_W  = 10;

  // shared multiplier geometry
  localparam int MUL_A_W  = 23;
  localparam int MUL_B_W  = 16;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

  // x / 100 == (x * RECIP_100) >> RECIP_SHIFT, low by at most one, for x < 2**23
  localparam logic [MUL_B_W-1:0] RECIP_100   = 16'd41943;
  localparam int                 RECIP_SHIFT = 22;
  localparam logic [PCT_W-1:0]   PCT_MAX     = 7'd100;
  localparam int                 STEP_SHIFT  = 7;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;
  localparam logic [PCT_W-1:0]    PCT_RST    = 7'd44;

  // item kinds
  localparam logic [1:0] KIND_CMD    = 2'd0;
  localparam logic [1:0] KIND_SWITCH = 2'd1;
  localparam logic [1:0] KIND_ADC    = 2'd2;

  // command bytes
  localparam logic [7:0] CMD_TEST_OFF = 8'h80;
  localparam logic [7:0] CMD_TEST_ON  = 8'h81;
  localparam logic [7:0] CMD_DEBUG    = 8'h2A;
  localparam logic [7:0] CMD_BUZZ_ON  = 8'hF0;
  localparam logic [7:0] CMD_BUZZ_OFF = 8'hF1;
  localparam logic [7:0] CMD_SHOW_BUF = 8'hF4;
  localparam logic [7:0] CMD_STATUS   = 8'hF7;
  localparam logic [7:0] CMD_CLOSE    = 8'hF8;
  localparam logic [7:0] CMD_OPEN     = 8'hF9;
  localparam logic [7:0] CMD_POS      = 8'hFF;

  localparam logic [7:0] RPL_DEBUG    = 8'h7B;
  localparam logic [7:0] RPL_MOVING   = 8'h0A;
  localparam logic [7:0] RPL_STOPPED  = 8'h00;

  // gate positions
  localparam logic [1:0] POS_UNKNOWN = 2'd0;
  localparam logic [1:0] POS_OPEN    = 2'd1;
  localparam logic [1:0] POS_CLOSED  = 2'd2;

  // display events
  localparam logic [2:0] DISP_NONE    = 3'd0;
  localparam logic [2:0] DISP_NORMAL  = 3'd1;
  localparam logic [2:0] DISP_TEST    = 3'd2;
  localparam logic [2:0] DISP_UNKNOWN = 3'd3;
  localparam logic [2:0] DISP_OPENED  = 3'd4;
  localparam logic [2:0] DISP_CLOSED  = 3'd5;
  localparam logic [2:0] DISP_SHOWBUF = 3'd6;

  typedef enum logic {
    REG_PERIOD,
    REG_MAX_PCT
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    D_IDLE,
    D_PCT,
    D_RECIP,
    D_HUND,
    D_FIX,
    D_SAMPLE,
    D_CMP
  } duty_state_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         rx_byte;
    logic               open_limit;
    logic               close_limit;
    logic [SENSE_W-1:0] sense_main;
    logic [SENSE_W-1:0] sense_aux;
  } gmcc_in_t;

  typedef struct packed {
    logic                tx_valid;
    logic [7:0]          tx_byte;
    logic                last_of_run;
    logic [PERIOD_W-1:0] pwm_compare;
    logic                motor_enable;
    logic                motor_close_dir;
    logic                buzzer_on;
    logic [1:0]          gate_state;
    logic                gate_moving;
    logic                test_mode_on;
    logic [2:0]          display_event;
  } gmcc_out_t;

  typedef struct packed {
    logic [1:0] gate_pos;
    logic [1:0] switch_pos;
    logic       moving;
    logic       test;
    logic       debug;
    logic       buzz;
    logic       drv_en;
    logic       drv_dir;
  } gate_stat_t;

  typedef struct packed {
    logic                done;
    logic [PERIOD_W-1:0] compare;
  } duty_rsp_t;

endpackage

// File: hdl/gate_motor_command_controller.sv
// ----------------------------------------------------------------------------
// Gate motor command controller
// Command decoding, limit switch tracking, reply sequencing and PWM compare.
// ----------------------------------------------------------------------------
// One item at a time: a new item is taken only when idle. A command byte or
// switch tick gives one to two results, each loaded when the output is free.
// An ADC sample first runs the compare sequencer, which makes four passes through one
// shared 23x16 multiplier plus a quotient correction and a final compare, then gives
// one result, or four reply results in debug mode. The last result sits in the
// output register while the next item is taken. Config writes take effect at
// once and are meant for idle periods only.

`include "gate_motor_command_controller_defines.svh"

module gate_motor_command_controller import gmcc_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [PERIOD_W-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gmcc_in_t            in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gmcc_out_t           out_o
);

  ctrl_state_e state_q, state_d;

  logic [PERIOD_W-1:0] period_q;
  logic [PCT_W-1:0]    pct_q;
  gate_stat_t          stat_q, stat_d;
  logic [2:0]          disp_q, disp_d;
  logic [PERIOD_W-1:0] compare_q;
  logic [7:0]          tx_q [4];
  logic [7:0]          tx_d [4];
  logic [2:0]          ntx_d;
  logic                has_tx_q;
  logic [1:0]          last_idx_q;
  logic [1:0]          idx_q;
  logic                out_valid_q;
  gmcc_out_t           out_q;

  logic                accept;
  logic                emit_load;
  logic                duty_start;
  duty_rsp_t           duty_rsp;

  gmcc_duty #(
    .ADC_BITS (ADC_BITS)
  ) u_duty (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (duty_start),
    .sense_i  (in_i.sense_main),
    .period_i (period_q),
    .pct_i    (pct_q),
    .rsp_o    (duty_rsp)
  );

  assign accept = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = (in_i.cmd == KIND_ADC) ? ST_CALC : ST_EMIT;
      end
      ST_CALC: if (duty_rsp.done) state_d = ST_EMIT;
      ST_EMIT: if (emit_load && idx_q == last_idx_q) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = 1'b0;
    emit_load  = 1'b0;
    duty_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        duty_start = in_valid_i && (in_i.cmd == KIND_ADC);
      end
      ST_EMIT: emit_load = !out_valid_q || out_ready_i;
      default: in_ready_o = 1'b0;
    endcase
  end

  // item decode
  always_comb begin
    stat_d = stat_q;
    disp_d = DISP_NONE;
    ntx_d  = '0;
    for (int i = 0; i < 4; i++) begin
      tx_d[i] = '0;
    end
    unique case (in_i.cmd)
      KIND_CMD: begin
        unique case (in_i.rx_byte)
          CMD_TEST_ON: begin
            tx_d[0] = CMD_TEST_ON; ntx_d = 3'd1; stat_d.test = 1'b1; disp_d = DISP_TEST;
          end
          CMD_TEST_OFF: begin
            tx_d[0] = CMD_TEST_OFF; ntx_d = 3'd1; stat_d.test = 1'b0; disp_d = DISP_NORMAL;
          end
          CMD_DEBUG: begin
            stat_d.debug = !stat_q.debug;
            tx_d[0] = CMD_DEBUG; tx_d[1] = RPL_DEBUG; ntx_d = 3'd2;
          end
          CMD_BUZZ_ON: begin
            tx_d[0] = CMD_BUZZ_ON; ntx_d = 3'd1; stat_d.buzz = 1'b1;
          end
          CMD_BUZZ_OFF: begin
            tx_d[0] = CMD_BUZZ_OFF; ntx_d = 3'd1; stat_d.buzz = 1'b0;
          end
          CMD_SHOW_BUF: disp_d = DISP_SHOWBUF;
          CMD_STATUS: begin
            tx_d[0] = CMD_STATUS;
            tx_d[1] = stat_q.moving ? RPL_MOVING : RPL_STOPPED;
            ntx_d   = 3'd2;
          end
          CMD_CLOSE, CMD_OPEN: begin
            tx_d[0]         = in_i.rx_byte;
            ntx_d           = 3'd1;
            stat_d.drv_dir  = (in_i.rx_byte == CMD_CLOSE);
            stat_d.drv_en   = 1'b1;
            stat_d.gate_pos = POS_UNKNOWN;
            stat_d.moving   = 1'b1;
            disp_d          = DISP_UNKNOWN;
          end
          CMD_POS: begin
            tx_d[0] = CMD_POS; tx_d[1] = 8'(stat_q.gate_pos); ntx_d = 3'd2;
          end
          default: ntx_d = '0;
        endcase
      end
      KIND_SWITCH: begin
        if (in_i.open_limit && !in_i.close_limit) begin
          if (stat_q.switch_pos != POS_OPEN) begin
            stat_d.drv_en     = 1'b0;
            stat_d.moving     = 1'b0;
            stat_d.gate_pos   = POS_OPEN;
            stat_d.switch_pos = POS_OPEN;
            disp_d            = DISP_OPENED;
          end
        end else if (in_i.close_limit && !in_i.open_limit) begin
          if (stat_q.switch_pos != POS_CLOSED) begin
            stat_d.drv_en     = 1'b0;
            stat_d.moving     = 1'b0;
            stat_d.gate_pos   = POS_CLOSED;
            stat_d.switch_pos = POS_CLOSED;
            disp_d            = DISP_CLOSED;
          end
        end else if (!in_i.open_limit && !in_i.close_limit) begin
          if (stat_q.switch_pos != POS_UNKNOWN) begin
            stat_d.gate_pos   = POS_UNKNOWN;
            stat_d.switch_pos = POS_UNKNOWN;
            disp_d            = DISP_UNKNOWN;
          end
        end
      end
      KIND_ADC: begin
        if (stat_q.debug) begin
          tx_d[0] = 8'(in_i.sense_main[SENSE_W-1:8]);
          tx_d[1] = in_i.sense_main[7:0];
          tx_d[2] = 8'(in_i.sense_aux[SENSE_W-1:8]);
          tx_d[3] = in_i.sense_aux[7:0];
          ntx_d   = 3'd4;
        end
      end
      default: ntx_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      period_q    <= PERIOD_RST;
      pct_q       <= PCT_RST;
      stat_q      <= '0;
      compare_q   <= '0;
      disp_q      <= DISP_NONE;
      has_tx_q    <= 1'b0;
      last_idx_q  <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PERIOD:  period_q <= cfg_data_i;
          REG_MAX_PCT: pct_q    <= cfg_data_i[PCT_W-1:0];
          default:     period_q <= period_q;
        endcase
      end
      if (accept) begin
        stat_q     <= stat_d;
        disp_q     <= disp_d;
        has_tx_q   <= (ntx_d != '0);
        last_idx_q <= (ntx_d == '0) ? 2'd0 : 2'(ntx_d - 3'd1);
        idx_q      <= '0;
      end
      if (state_q == ST_CALC && duty_rsp.done) begin
        compare_q <= duty_rsp.compare;
      end
      if (emit_load) begin
        idx_q       <= idx_q + 2'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tx_q <= tx_d;
    end
    if (emit_load) begin
      out_q.tx_valid        <= has_tx_q;
      out_q.tx_byte         <= has_tx_q ? tx_q[idx_q] : 8'h00;
      out_q.last_of_run     <= (idx_q == last_idx_q);
      out_q.pwm_compare     <= compare_q;
      out_q.motor_enable    <= stat_q.drv_en;
      out_q.motor_close_dir <= stat_q.drv_dir;
      out_q.buzzer_on       <= stat_q.buzz;
      out_q.gate_state      <= stat_q.gate_pos;
      out_q.gate_moving     <= stat_q.moving;
      out_q.test_mode_on    <= stat_q.test;
      out_q.display_event   <= disp_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `GMCC_ASSERT(a_adc_calc, (accept && in_i.cmd == KIND_ADC) |=> (state_q == ST_CALC), "ADC not in calc")
  `GMCC_ASSERT_IMP(a_more_pending, out_valid_o && !out_o.last_of_run, state_q == ST_EMIT, "results lost")
  `GMCC_ASSERT_IMP(a_silent_last, out_valid_o && !out_o.tx_valid, out_o.last_of_run, "silent result not last")

endmodule

// File: hdl/gmcc_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// One unsigned multiply per cycle with a registered product.
// ----------------------------------------------------------------------------
module gmcc_mul import gmcc_pkg::*; (
  input  logic               clk_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic [MUL_P_W-1:0] prod_o
);

  logic [MUL_P_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// File: hdl/gmcc_duty.sv
// ----------------------------------------------------------------------------
// PWM compare sequencer
// Computes period - (period*pct/100)*(sample>>3)/128, 0 if not positive, period-1
// if the term is 0, on the shared multiplier; /100 by reciprocal, one correction step.
// ----------------------------------------------------------------------------
`include "gate_motor_command_controller_defines.svh"

module gmcc_duty import gmcc_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SENSE_W-1:0]  sense_i,
  input  logic [PERIOD_W-1:0] period_i,
  input  logic [PCT_W-1:0]    pct_i,
  output duty_rsp_t           rsp_o
);

  localparam int ExtW  = (ADC_BITS > SENSE_W) ? ADC_BITS : SENSE_W;
  localparam int StepW = ADC_BITS - 3;

  duty_state_e state_q, state_d;

  logic [ExtW-1:0]     sense_ext;
  logic [StepW-1:0]    step_q;
  logic [MUL_A_W-1:0]  x_q;
  logic [MUL_P_W-RECIP_SHIFT-1:0] q0_q;
  logic [PERIOD_W-1:0] quot_q;
  logic [MUL_A_W-1:0]  rem;
  logic [PCT_W-1:0]    pct_sat;
  logic [MUL_P_W-STEP_SHIFT-1:0] scaled;

  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  prod;

  gmcc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign sense_ext = ExtW'(sense_i);
  assign pct_sat   = (pct_i > PCT_MAX) ? PCT_MAX : pct_i;
  assign rem       = x_q - prod[MUL_A_W-1:0];
  assign scaled    = prod[MUL_P_W-1:STEP_SHIFT];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      D_IDLE:   if (start_i) state_d = D_PCT;
      D_PCT:    state_d = D_RECIP;
      D_RECIP:  state_d = D_HUND;
      D_HUND:   state_d = D_FIX;
      D_FIX:    state_d = D_SAMPLE;
      D_SAMPLE: state_d = D_CMP;
      D_CMP:    state_d = D_IDLE;
      default:  state_d = D_IDLE;
    endcase
  end

  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    rsp_o.done    = 1'b0;
    rsp_o.compare = '0;
    unique case (state_q)
      D_PCT: begin
        mul_a = MUL_A_W'(period_i);
        mul_b = MUL_B_W'(pct_sat);
      end
      D_RECIP: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = RECIP_100;
      end
      D_HUND: begin
        mul_a = MUL_A_W'(prod[MUL_P_W-1:RECIP_SHIFT]);
        mul_b = MUL_B_W'(PCT_MAX);
      end
      D_SAMPLE: begin
        mul_a = MUL_A_W'(quot_q);
        mul_b = MUL_B_W'(step_q);
      end
      D_CMP: begin
        rsp_o.done = 1'b1;
        if (scaled >= (MUL_P_W-STEP_SHIFT)'(period_i)) begin
          rsp_o.compare = '0;
        end else if (scaled == '0) begin
          rsp_o.compare = period_i - 1'b1;
        end else begin
          rsp_o.compare = period_i - scaled[PERIOD_W-1:0];
        end
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE && start_i) begin
      step_q <= sense_ext[ADC_BITS-1:3];
    end
    if (state_q == D_RECIP) begin
      x_q <= prod[MUL_A_W-1:0];
    end
    if (state_q == D_HUND) begin
      q0_q <= prod[MUL_P_W-1:RECIP_SHIFT];
    end
    if (state_q == D_FIX) begin
      quot_q <= PERIOD_W'(q0_q + ((rem >= MUL_A_W'(PCT_MAX)) ? 1'b1 : 1'b0));
    end
  end

  `GMCC_ASSERT_IMP(a_start_idle, start_i, state_q == D_IDLE, "duty start while busy")
  `GMCC_ASSERT_IMP(a_rem_range, state_q == D_FIX, rem < MUL_A_W'(200), "reciprocal error")
  `GMCC_ASSERT_IMP(a_cmp_range, rsp_o.done, (rsp_o.compare < period_i) || (rsp_o.compare == '0), "compare not below period")

endmodule
